@@ sv/tmlg_pkg.sv @@
// Package for the texture mip layout generator.
// Holds field widths, status and format codes, the shared multiplier request type
// and the format decode functions. No dependencies.
package tmlg_pkg;

    // Field widths
    localparam int DIM_W      = 15;
    localparam int MIPS_W     = 4;
    localparam int ARR_W      = 7;
    localparam int FMT_W      = 4;
    localparam int PITCH_W    = 18;
    localparam int ROWS_W     = 15;
    localparam int SPITCH_W   = 32;
    localparam int OFFSET_W   = 38;
    localparam int SLICE_W    = 9;
    localparam int STATUS_W   = 2;

    // Internal widths
    localparam int MIPCNT_W   = 5;   // effective mip count, 1..MAX_MIP_LEVELS (1..15 by default)
    localparam int SLICES_W   = 10;  // array size, times six for a cube map
    localparam int BLK_W      = 14;  // 4x4 block count along one side
    localparam int SHIFT_W    = 3;   // log2 of bytes per block or pixel
    localparam int MUL_A_W    = PITCH_W;
    localparam int MUL_B_W    = ROWS_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // Parameter defaults
    localparam int MAX_SUBRESOURCES_DEF = 64;
    localparam int MAX_MIP_LEVELS_DEF   = 15;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_FMT  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_ARR = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_MANY = 2'd3;

    // Format codes
    localparam logic [FMT_W-1:0] FMT_BC1       = 4'd0;
    localparam logic [FMT_W-1:0] FMT_BC2       = 4'd1;
    localparam logic [FMT_W-1:0] FMT_BC3       = 4'd2;
    localparam logic [FMT_W-1:0] FMT_BC7       = 4'd3;
    localparam logic [FMT_W-1:0] FMT_BC6H_U    = 4'd4;
    localparam logic [FMT_W-1:0] FMT_BC6H_S    = 4'd5;
    localparam logic [FMT_W-1:0] FMT_RG16F     = 4'd6;
    localparam logic [FMT_W-1:0] FMT_RG32F     = 4'd7;
    localparam logic [FMT_W-1:0] FMT_RGBA8     = 4'd8;
    localparam logic [FMT_W-1:0] FMT_BGRA8     = 4'd9;

    // Request to the shared multiplier
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    // Format decode: known code
    function automatic logic fmt_known(input logic [FMT_W-1:0] fmt);
        logic known;
        case (fmt) inside
            [FMT_BC1:FMT_BGRA8]: known = 1'b1;
            default:             known = 1'b0;
        endcase
        return known;
    endfunction

    // Format decode: block compressed
    function automatic logic fmt_compressed(input logic [FMT_W-1:0] fmt);
        return (fmt <= FMT_BC6H_S);
    endfunction

    // Format decode: log2 of bytes per block or per pixel
    function automatic logic [SHIFT_W-1:0] fmt_shift(input logic [FMT_W-1:0] fmt);
        logic [SHIFT_W-1:0] sh;
        case (fmt) inside
            FMT_BC1, FMT_RG32F:         sh = 3'd3;
            [FMT_BC2:FMT_BC6H_S]:       sh = 3'd4;
            FMT_RG16F, FMT_RGBA8,
            FMT_BGRA8:                  sh = 3'd2;
            default:                    sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage

@@ sv/texture_mip_layout_generator.sv @@
// Texture mip layout generator: one descriptor in, one beat per subresource out
// (a single beat on error). In the check state a format or array size error result goes
// straight to output; else the total state tests the subresource count from the shared
// multiplier. Each subresource passes pitch, multiply and output states plus any output
// stall; in_ready is high only in idle, so it returns after the last result is taken.
// Reset (rst_n low, async) returns the sequencer to idle, clearing its registers.
module texture_mip_layout_generator
#(
    parameter int MAX_SUBRESOURCES = tmlg_pkg::MAX_SUBRESOURCES_DEF,
    parameter int MAX_MIP_LEVELS   = tmlg_pkg::MAX_MIP_LEVELS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tmlg_pkg::DIM_W-1:0]      width,
    input  logic [tmlg_pkg::DIM_W-1:0]      height,
    input  logic [tmlg_pkg::MIPS_W-1:0]     mip_count,
    input  logic [tmlg_pkg::ARR_W-1:0]      array_size,
    input  logic                            cube_map,
    input  logic [tmlg_pkg::FMT_W-1:0]      format_code,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tmlg_pkg::PITCH_W-1:0]    row_pitch,
    output logic [tmlg_pkg::ROWS_W-1:0]     row_count,
    output logic [tmlg_pkg::SPITCH_W-1:0]   slice_pitch,
    output logic [tmlg_pkg::OFFSET_W-1:0]   byte_offset,
    output logic [tmlg_pkg::SLICE_W-1:0]    slice_index,
    output logic [tmlg_pkg::MIPS_W-1:0]     mip_index,
    output logic                            last,
    output logic [tmlg_pkg::STATUS_W-1:0]   status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TOTAL,
        ST_PITCH,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t                             state_reg, state_next;

    // Descriptor
    logic [tmlg_pkg::DIM_W-1:0]         w0_reg, w0_next;
    logic [tmlg_pkg::DIM_W-1:0]         h0_reg, h0_next;
    logic [tmlg_pkg::FMT_W-1:0]         fmt_reg, fmt_next;
    logic [tmlg_pkg::MIPCNT_W-1:0]      mips_reg, mips_next;
    logic [tmlg_pkg::SLICES_W-1:0]      slices_reg, slices_next;

    // Walk state
    logic [tmlg_pkg::DIM_W-1:0]         w_reg, w_next;
    logic [tmlg_pkg::DIM_W-1:0]         h_reg, h_next;
    logic [tmlg_pkg::SLICE_W-1:0]       s_reg, s_next;
    logic [tmlg_pkg::MIPS_W-1:0]        m_reg, m_next;
    logic [tmlg_pkg::OFFSET_W-1:0]      offset_reg, offset_next;

    // Result
    logic [tmlg_pkg::PITCH_W-1:0]       rp_reg, rp_next;
    logic [tmlg_pkg::ROWS_W-1:0]        rc_reg, rc_next;
    logic                               last_reg, last_next;
    logic [tmlg_pkg::STATUS_W-1:0]      status_reg, status_next;

    tmlg_pkg::mul_req_t                 mul_req;
    logic [tmlg_pkg::MUL_P_W-1:0]       mul_prod;

    // Input decode
    logic [tmlg_pkg::MIPCNT_W-1:0]      in_mips;
    logic [tmlg_pkg::SLICES_W-1:0]      in_slices;
    logic [tmlg_pkg::SLICES_W-1:0]      arr_ext;

    // Pitch decode
    logic                               comp;
    logic [tmlg_pkg::SHIFT_W-1:0]       shift;
    logic [tmlg_pkg::BLK_W-1:0]         bw, bh;
    logic [tmlg_pkg::DIM_W:0]           w_round, h_round;
    logic [tmlg_pkg::PITCH_W+1:0]       rp_full;
    logic                               mip_end, slice_end;

    tmlg_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // Effective mip count and slice count
    always_comb
    begin
        in_mips = tmlg_pkg::MIPCNT_W'(mip_count);
        if (mip_count == '0)
        begin
            in_mips = tmlg_pkg::MIPCNT_W'(1);
        end
        else if (in_mips > tmlg_pkg::MIPCNT_W'(MAX_MIP_LEVELS))
        begin
            in_mips = tmlg_pkg::MIPCNT_W'(MAX_MIP_LEVELS);
        end
        arr_ext   = tmlg_pkg::SLICES_W'(array_size);
        in_slices = cube_map ? ((arr_ext << 2) + (arr_ext << 1)) : arr_ext;
    end

    // Row pitch and row count of the current mip
    always_comb
    begin
        comp    = tmlg_pkg::fmt_compressed(fmt_reg);
        shift   = tmlg_pkg::fmt_shift(fmt_reg);
        w_round = (tmlg_pkg::DIM_W+1)'(w_reg) + (tmlg_pkg::DIM_W+1)'(3);
        h_round = (tmlg_pkg::DIM_W+1)'(h_reg) + (tmlg_pkg::DIM_W+1)'(3);
        bw      = w_round[tmlg_pkg::DIM_W:2];
        bh      = h_round[tmlg_pkg::DIM_W:2];
        if (bw == '0)
        begin
            bw = tmlg_pkg::BLK_W'(1);
        end
        if (bh == '0)
        begin
            bh = tmlg_pkg::BLK_W'(1);
        end
        if (comp)
        begin
            rp_full = (tmlg_pkg::PITCH_W+2)'(bw) << shift;
        end
        else
        begin
            rp_full = (tmlg_pkg::PITCH_W+2)'(w_reg) << shift;
        end
    end

    assign mip_end   = ({1'b0, m_reg} == mips_reg - tmlg_pkg::MIPCNT_W'(1));
    assign slice_end = ({1'b0, s_reg} == tmlg_pkg::SLICES_W'(slices_reg - 1'b1));

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        w0_next     = w0_reg;
        h0_next     = h0_reg;
        fmt_next    = fmt_reg;
        mips_next   = mips_reg;
        slices_next = slices_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        s_next      = s_reg;
        m_next      = m_reg;
        offset_next = offset_reg;
        rp_next     = rp_reg;
        rc_next     = rc_reg;
        last_next   = last_reg;
        status_next = status_reg;
        mul_req     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    w0_next     = width;
                    h0_next     = height;
                    fmt_next    = format_code;
                    mips_next   = in_mips;
                    slices_next = in_slices;
                    state_next  = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // Total subresource count on the shared multiplier
                mul_req.en  = 1'b1;
                mul_req.a   = tmlg_pkg::MUL_A_W'(slices_reg);
                mul_req.b   = tmlg_pkg::MUL_B_W'(mips_reg);
                rp_next     = '0;
                rc_next     = '0;
                offset_next = '0;
                s_next      = '0;
                m_next      = '0;
                w_next      = w0_reg;
                h_next      = h0_reg;
                last_next   = 1'b1;
                if (!tmlg_pkg::fmt_known(fmt_reg))
                begin
                    status_next = tmlg_pkg::STAT_BAD_FMT;
                    state_next  = ST_EMIT;
                end
                else if (slices_reg == '0)
                begin
                    status_next = tmlg_pkg::STAT_ZERO_ARR;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    status_next = tmlg_pkg::STAT_OK;
                    state_next  = ST_TOTAL;
                end
            end

            ST_TOTAL:
            begin
                if (mul_prod > tmlg_pkg::MUL_P_W'(MAX_SUBRESOURCES))
                begin
                    status_next = tmlg_pkg::STAT_TOO_MANY;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PITCH;
                end
            end

            ST_PITCH:
            begin
                rp_next    = rp_full[tmlg_pkg::PITCH_W-1:0];
                rc_next    = comp ? tmlg_pkg::ROWS_W'(bh) : h_reg;
                last_next  = mip_end && slice_end;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = rp_reg;
                mul_req.b  = rc_reg;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        offset_next = offset_reg
                                    + tmlg_pkg::OFFSET_W'(mul_prod[tmlg_pkg::SPITCH_W-1:0]);
                        if (mip_end)
                        begin
                            m_next = '0;
                            s_next = s_reg + 1'b1;
                            w_next = w0_reg;
                            h_next = h0_reg;
                        end
                        else
                        begin
                            m_next = m_reg + 1'b1;
                            w_next = (w_reg > tmlg_pkg::DIM_W'(1)) ? (w_reg >> 1)
                                                                   : tmlg_pkg::DIM_W'(1);
                            h_next = (h_reg > tmlg_pkg::DIM_W'(1)) ? (h_reg >> 1)
                                                                   : tmlg_pkg::DIM_W'(1);
                        end
                        state_next = ST_PITCH;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            w0_reg     <= '0;
            h0_reg     <= '0;
            fmt_reg    <= '0;
            mips_reg   <= '0;
            slices_reg <= '0;
            w_reg      <= '0;
            h_reg      <= '0;
            s_reg      <= '0;
            m_reg      <= '0;
            offset_reg <= '0;
            rp_reg     <= '0;
            rc_reg     <= '0;
            last_reg   <= 1'b0;
            status_reg <= tmlg_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            w0_reg     <= w0_next;
            h0_reg     <= h0_next;
            fmt_reg    <= fmt_next;
            mips_reg   <= mips_next;
            slices_reg <= slices_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            s_reg      <= s_next;
            m_reg      <= m_next;
            offset_reg <= offset_next;
            rp_reg     <= rp_next;
            rc_reg     <= rc_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

    // Ports
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign row_pitch   = rp_reg;
    assign row_count   = rc_reg;
    assign slice_pitch = (status_reg == tmlg_pkg::STAT_OK)
                       ? mul_prod[tmlg_pkg::SPITCH_W-1:0] : '0;
    assign byte_offset = offset_reg;
    assign slice_index = s_reg;
    assign mip_index   = m_reg;
    assign last        = last_reg;
    assign status      = status_reg;

endmodule

@@ sv/tmlg_mul.sv @@
// Shared multiplier for the texture mip layout generator.
// One registered 18x15 product, loaded only on a request. Depends on tmlg_pkg.
module tmlg_mul
(
    input  logic                          clk,
    input  tmlg_pkg::mul_req_t            req,
    output logic [tmlg_pkg::MUL_P_W-1:0]  prod
);

    logic [tmlg_pkg::MUL_P_W-1:0] prod_reg;
    logic [tmlg_pkg::MUL_P_W-1:0] prod_next;

    // Product, held between requests
    always_comb
    begin
        prod_next = prod_reg;
        if (req.en)
        begin
            prod_next = tmlg_pkg::MUL_P_W'(req.a) * tmlg_pkg::MUL_P_W'(req.b);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
